/* rtl/core/lamb_pkg.sv */
// shared types, constants and helpers of the look-at matrix builder
// no dependencies; used by lamb_ctrl, lamb_dp and the top level
package lamb_pkg;

  localparam int unsigned THR_W      = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1074;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [1:0] ROW_LAST    = 2'd2;
  localparam logic [4:0] SQRT_LAST   = 5'd31;
  localparam logic [4:0] DIV_LAST    = 5'd30;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG,
    OP_NORM,
    OP_ZERO,
    OP_MUL_SQ,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_T2,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_PROD_STORE,
    OP_THRESH,
    OP_SELECT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAG,
    S_NORM,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT_INIT,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_STORE,
    S_PA_MUL,
    S_PA_ACC,
    S_PB_MUL,
    S_PB_ACC,
    S_P_STORE,
    S_T2_MUL,
    S_T2_ACC,
    S_THRESH,
    S_SELECT,
    S_EMIT
  } ctrl_state_t;

  // sel: 0 = forward pass / cross product, 1 = right pass / new up axis
  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic       sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mx_zero;
    logic norm_done;
  } dp_stat_t;

  function automatic logic [1:0] idx_p1(input logic [1:0] i);
    case (i)
      2'd0:    idx_p1 = 2'd1;
      2'd1:    idx_p1 = 2'd2;
      default: idx_p1 = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_p2(input logic [1:0] i);
    case (i)
      2'd0:    idx_p2 = 2'd2;
      2'd1:    idx_p2 = 2'd0;
      default: idx_p2 = 2'd1;
    endcase
  endfunction

endpackage

/* rtl/core/lamb_dp.sv */
// datapath of the look-at matrix builder: vector registers, shared multiplier,
// accumulator, iterative square root and divider; depends on lamb_pkg
module lamb_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lamb_pkg::dp_cmd_t         cmd,
  output lamb_pkg::dp_stat_t        stat,
  input  logic                      cfg_wr_en,
  input  logic [lamb_pkg::THR_W-1:0] cfg_wr_data,
  input  logic signed [31:0]        in_eye_x,
  input  logic signed [31:0]        in_eye_y,
  input  logic signed [31:0]        in_eye_z,
  input  logic signed [31:0]        in_target_x,
  input  logic signed [31:0]        in_target_y,
  input  logic signed [31:0]        in_target_z,
  input  logic signed [31:0]        in_up_hint_x,
  input  logic signed [31:0]        in_up_hint_y,
  input  logic signed [31:0]        in_up_hint_z,
  output logic signed [31:0]        out_right_part,
  output logic signed [31:0]        out_upward_part,
  output logic signed [31:0]        out_forward_part,
  output logic signed [31:0]        out_position_part,
  output logic                      out_fallback_used
);
  import lamb_pkg::*;

  logic signed [31:0] eye_r [3];
  logic signed [31:0] up_r [3];
  logic signed [63:0] v_r [3];
  logic [63:0]        m_r [3];
  logic [63:0]        mx_r;
  logic signed [6:0]  sh_r;
  logic [63:0]        sumsq_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic [63:0]        sq_x_r;
  logic [63:0]        sq_root_r;
  logic [63:0]        sq_bit_r;
  logic [30:0]        div_rem_r;
  logic [30:0]        div_nq_r;
  logic signed [31:0] f_r [3];
  logic signed [31:0] r_r [3];
  logic signed [31:0] nu_r [3];
  logic signed [31:0] saved_r [3];
  logic               fb_r;
  logic [THR_W-1:0]   thr_r;

  logic [1:0]         p1, p2;
  logic signed [31:0] mul_a, mul_b;
  logic signed [32:0] d_vec [3];
  logic [63:0]        mag [3];
  logic [63:0]        mag_max;
  logic [63:0]        sq_trial;
  logic               sq_ge;
  logic [30:0]        s_val;
  logic [60:0]        div_num;
  logic [31:0]        div_trial;
  logic               div_ge;
  logic [31:0]        div_sub;
  logic signed [31:0] div_q;
  logic signed [8:0]  thr_e;
  logic [8:0]         thr_e_neg;
  logic [127:0]       thr_lhs, thr_rhs;
  logic               fb_nxt;

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
    logic [63:0] mg;
    logic [64:0] q;
    logic [64:0] nq;
    begin
      mg = v[63] ? 64'(-v) : 64'(v);
      q  = ({1'b0, mg} + 65'd536870912) >> 30;
      nq = 65'd0 - q;
      if (v[63]) begin
        round_sat = (q > 65'd2147483648) ? 32'sh80000000 : $signed(nq[31:0]);
      end else begin
        round_sat = (q > 65'd2147483647) ? 32'sh7fffffff : $signed(q[31:0]);
      end
    end
  endfunction

  assign p1 = idx_p1(cmd.idx);
  assign p2 = idx_p2(cmd.idx);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_SQ: begin
        mul_a = $signed(m_r[cmd.idx][31:0]);
        mul_b = $signed(m_r[cmd.idx][31:0]);
      end
      OP_MUL_A: begin
        mul_a = cmd.sel ? f_r[p1] : up_r[p1];
        mul_b = cmd.sel ? r_r[p2] : f_r[p2];
      end
      OP_MUL_B: begin
        mul_a = cmd.sel ? f_r[p2] : up_r[p2];
        mul_b = cmd.sel ? r_r[p1] : f_r[p1];
      end
      OP_MUL_T2: begin
        mul_a = $signed({1'b0, thr_r});
        mul_b = $signed({1'b0, thr_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    d_vec[0] = {in_eye_x[31], in_eye_x} - {in_target_x[31], in_target_x};
    d_vec[1] = {in_eye_y[31], in_eye_y} - {in_target_y[31], in_target_y};
    d_vec[2] = {in_eye_z[31], in_eye_z} - {in_target_z[31], in_target_z};
    for (int i = 0; i < 3; i++) begin
      mag[i] = v_r[i][63] ? 64'(-v_r[i]) : 64'(v_r[i]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  // square root and divider steps
  assign sq_trial  = sq_root_r + sq_bit_r;
  assign sq_ge     = sq_x_r >= sq_trial;
  assign s_val     = sq_root_r[30:0];
  assign div_num   = {1'b0, m_r[cmd.idx][29:0], 30'd0} + {31'd0, s_val[30:1]};
  assign div_trial = {div_rem_r, div_nq_r[30]};
  assign div_ge    = div_trial >= {1'b0, s_val};
  assign div_sub   = div_trial - {1'b0, s_val};
  assign div_q     = v_r[cmd.idx][63] ? -$signed({1'b0, div_nq_r}) : $signed({1'b0, div_nq_r});

  // degenerate test: sumsq against t^2 * 2^e, exact
  always_comb begin
    thr_e     = 9'sd60 + $signed({sh_r[6], sh_r, 1'b0});
    thr_e_neg = 9'(-thr_e);
    thr_lhs   = {64'd0, sumsq_r};
    thr_rhs   = {64'd0, acc_r};
    if (thr_e < 0) begin
      thr_lhs = thr_lhs << thr_e_neg[2:0];
    end else if (thr_e < 9'sd64) begin
      thr_rhs = thr_rhs << thr_e[5:0];
    end
    fb_nxt = (thr_r != '0) &&
             ((sumsq_r == '0) || (thr_e >= 9'sd64) || (thr_lhs < thr_rhs));
  end

  assign stat.mx_zero   = (mx_r == '0);
  assign stat.norm_done = (mx_r[63:30] == '0) && mx_r[29];

  // control-side state: threshold, saved right axis, fallback flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      saved_r[0] <= ONE_Q30;
      saved_r[1] <= '0;
      saved_r[2] <= '0;
      fb_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (cmd.op == OP_THRESH) fb_r <= fb_nxt;
      if (cmd.op == OP_SELECT && !fb_r) begin
        for (int i = 0; i < 3; i++) saved_r[i] <= r_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        eye_r[0] <= in_eye_x;
        eye_r[1] <= in_eye_y;
        eye_r[2] <= in_eye_z;
        up_r[0]  <= in_up_hint_x;
        up_r[1]  <= in_up_hint_y;
        up_r[2]  <= in_up_hint_z;
        for (int i = 0; i < 3; i++) v_r[i] <= {{31{d_vec[i][32]}}, d_vec[i]};
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) m_r[i] <= mag[i];
        mx_r <= mag_max;
        sh_r <= '0;
      end
      OP_NORM: begin
        if (mx_r[63:30] != '0) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          mx_r <= mx_r >> 1;
          sh_r <= sh_r - 7'sd1;
        end else begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          mx_r <= mx_r << 1;
          sh_r <= sh_r + 7'sd1;
        end
      end
      OP_ZERO: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd.sel) r_r[i] <= '0;
          else f_r[i] <= '0;
        end
        sumsq_r <= '0;
        sh_r    <= '0;
      end
      OP_ACC_LOAD: acc_r <= prod_r;
      OP_ACC_ADD:  acc_r <= acc_r + prod_r;
      OP_ACC_SUB:  acc_r <= acc_r - prod_r;
      OP_SQRT_INIT: begin
        sq_x_r    <= acc_r;
        sumsq_r   <= acc_r;
        sq_root_r <= '0;
        sq_bit_r  <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_x_r    <= sq_x_r - sq_trial;
          sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIV_INIT: begin
        div_rem_r <= {1'b0, div_num[60:31]};
        div_nq_r  <= div_num[30:0];
      end
      OP_DIV_STEP: begin
        div_rem_r <= div_ge ? div_sub[30:0] : div_trial[30:0];
        div_nq_r  <= {div_nq_r[29:0], div_ge};
      end
      OP_DIV_STORE: begin
        if (cmd.sel) r_r[cmd.idx] <= div_q;
        else f_r[cmd.idx] <= div_q;
      end
      OP_PROD_STORE: begin
        if (cmd.sel) nu_r[cmd.idx] <= round_sat(acc_r);
        else v_r[cmd.idx] <= acc_r;
      end
      OP_SELECT: begin
        if (fb_r) begin
          for (int i = 0; i < 3; i++) r_r[i] <= saved_r[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_right_part    = r_r[cmd.idx];
  assign out_upward_part   = nu_r[cmd.idx];
  assign out_forward_part  = f_r[cmd.idx];
  assign out_position_part = eye_r[cmd.idx];
  assign out_fallback_used = fb_r;

endmodule

/* rtl/core/lamb_ctrl.sv */
// sequencer of the look-at matrix builder: steps the datapath through
// both unit scalings, the cross products and the row output; depends on lamb_pkg
module lamb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lamb_pkg::dp_stat_t stat,
  output lamb_pkg::dp_cmd_t  cmd,
  output logic [1:0]         out_row_index,
  output logic               out_last_row
);
  import lamb_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    cmd.sel   = sel_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          sel_nxt   = 1'b0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (stat.mx_zero) begin
          cmd.op  = OP_ZERO;
          idx_nxt = '0;
          state_nxt = sel_r ? S_T2_MUL : S_PA_MUL;
        end else if (stat.norm_done) begin
          idx_nxt   = '0;
          state_nxt = S_SQ_MUL;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SQ_MUL: begin
        cmd.op    = OP_MUL_SQ;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = (idx_r == '0) ? OP_ACC_LOAD : OP_ACC_ADD;
        if (idx_r == ROW_LAST) begin
          state_nxt = S_SQRT_INIT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt_r == SQRT_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_DIV_STORE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        if (idx_r == ROW_LAST) begin
          idx_nxt   = '0;
          state_nxt = sel_r ? S_T2_MUL : S_PA_MUL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_PA_MUL: begin
        cmd.op    = OP_MUL_A;
        state_nxt = S_PA_ACC;
      end
      S_PA_ACC: begin
        cmd.op    = OP_ACC_LOAD;
        state_nxt = S_PB_MUL;
      end
      S_PB_MUL: begin
        cmd.op    = OP_MUL_B;
        state_nxt = S_PB_ACC;
      end
      S_PB_ACC: begin
        cmd.op    = OP_ACC_SUB;
        state_nxt = S_P_STORE;
      end
      S_P_STORE: begin
        cmd.op = OP_PROD_STORE;
        if (idx_r == ROW_LAST) begin
          idx_nxt = '0;
          if (sel_r) begin
            state_nxt = S_EMIT;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = S_MAG;
          end
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_PA_MUL;
        end
      end
      S_T2_MUL: begin
        cmd.op    = OP_MUL_T2;
        state_nxt = S_T2_ACC;
      end
      S_T2_ACC: begin
        cmd.op    = OP_ACC_LOAD;
        state_nxt = S_THRESH;
      end
      S_THRESH: begin
        cmd.op    = OP_THRESH;
        state_nxt = S_SELECT;
      end
      S_SELECT: begin
        cmd.op    = OP_SELECT;
        idx_nxt   = '0;
        state_nxt = S_PA_MUL;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_r == ROW_LAST) begin
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_row_index = idx_r;
  assign out_last_row  = (idx_r == ROW_LAST);

endmodule

/* rtl/core/look_at_matrix_builder_core.sv */
// look-at matrix builder top level: sequencer plus datapath
// depends on lamb_pkg, lamb_ctrl and lamb_dp
//
// Builds the top three rows of a fixed-point look-at view matrix. Each
// request carries eye and target (Q16.16) and an up hint (Q2.30). The block
// forms forward = unit(eye - target), right = unit(up_hint x forward) and the
// new up axis = forward x right, and returns three result requests, one per
// row x, y, z, each with the right, up and forward components (Q2.30) and the
// eye component (Q16.16). When the right cross product is shorter than
// cfg_wr_data's threshold (Q2.30, reset 1074, about 1e-6) the last good right
// axis is reused (reset 1,0,0) and fallback_used is set on all three rows.
// Eye equal to target gives a zero forward axis. One request is handled at a
// time: in_ready is high only while the block is idle. The normalizing
// shifts of the forward and cross-product vectors span 0 to 29 and 0 to
// 33 bits; a zero vector skips its square root and divisions. The rows
// leave one per cycle as out_ready allows. The block uses one shared
// 32x32 multiplier, a one-bit-per-cycle square root and a restoring
// divider, used for six divisions per request. The threshold is written
// at any edge with cfg_wr_en high and should change only while idle.
module look_at_matrix_builder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [lamb_pkg::THR_W-1:0] cfg_wr_data,
  // input requests
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         in_eye_x,
  input  logic signed [31:0]         in_eye_y,
  input  logic signed [31:0]         in_eye_z,
  input  logic signed [31:0]         in_target_x,
  input  logic signed [31:0]         in_target_y,
  input  logic signed [31:0]         in_target_z,
  input  logic signed [31:0]         in_up_hint_x,
  input  logic signed [31:0]         in_up_hint_y,
  input  logic signed [31:0]         in_up_hint_z,
  // result requests
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_row_index,
  output logic signed [31:0]         out_right_part,
  output logic signed [31:0]         out_upward_part,
  output logic signed [31:0]         out_forward_part,
  output logic signed [31:0]         out_position_part,
  output logic                       out_last_row,
  output logic                       out_fallback_used
);
  import lamb_pkg::*;

  // command from the sequencer, status back from the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks the schedule and drives the handshakes
  lamb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stat          (stat),
    .cmd           (cmd),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

  // datapath: holds the vectors, threshold and saved right axis; the
  // output fields are read from its registers by the current row
  lamb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_eye_x          (in_eye_x),
    .in_eye_y          (in_eye_y),
    .in_eye_z          (in_eye_z),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .in_target_z       (in_target_z),
    .in_up_hint_x      (in_up_hint_x),
    .in_up_hint_y      (in_up_hint_y),
    .in_up_hint_z      (in_up_hint_z),
    .out_right_part    (out_right_part),
    .out_upward_part   (out_upward_part),
    .out_forward_part  (out_forward_part),
    .out_position_part (out_position_part),
    .out_fallback_used (out_fallback_used)
  );

endmodule

/* dv/tb_top.sv */
// self-checking testbench for look_at_matrix_builder_core
// depends on lamb_pkg and the core rtl; drives requests, predicts the three rows each
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import lamb_pkg::*;

  typedef struct packed {
    logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } view_req_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] rgt, upw, fwd, pos;
    logic               last, fb;
  } row_res_t;

  // one row of the directed table; has_row0 marks a hand-typed first row
  typedef struct {
    view_req_t  req;
    logic       has_row0;
    row_res_t   row0;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 400;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;
  logic in_valid, in_ready;
  view_req_t in_req;
  logic out_valid, out_ready;
  logic [1:0] out_row_index;
  logic signed [31:0] out_right_part, out_upward_part, out_forward_part, out_position_part;
  logic out_last_row, out_fallback_used;

  // predictor state: threshold and the saved right axis
  logic [THR_W-1:0]   pr_thresh;
  logic signed [31:0] pr_saved [3];

  row_res_t row_q [$];
  int  errors;
  int  cycles;
  int  hold_off;     // cycles the receiver still holds off
  bit  idle_out;     // receiver idles at random when set
  bit  idle_in;

  look_at_matrix_builder_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_eye_x(in_req.ex), .in_eye_y(in_req.ey), .in_eye_z(in_req.ez),
    .in_target_x(in_req.tx), .in_target_y(in_req.ty), .in_target_z(in_req.tz),
    .in_up_hint_x(in_req.ux), .in_up_hint_y(in_req.uy), .in_up_hint_z(in_req.uz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_right_part(out_right_part),
    .out_upward_part(out_upward_part), .out_forward_part(out_forward_part),
    .out_position_part(out_position_part), .out_last_row(out_last_row),
    .out_fallback_used(out_fallback_used)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------
  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    int_sqrt = r;
  endfunction

  // scales a vector to unit length in Q2.30, returns the scaled sum of
  // squares and the left shift that was applied (negative when shifted right)
  task automatic to_unit(input logic signed [63:0] v [3], output logic signed [63:0] u [3],
                         output logic [63:0] sumsq, output int lsh);
    logic [63:0] m [3];
    logic [63:0] mx, s, q;
    int sh;
    mx = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    sumsq = 0;
    lsh = 0;
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 30)) begin mx = mx >> 1; sh--; end
    while (mx < (64'd1 << 29)) begin mx = mx << 1; sh++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (sh >= 0) ? (m[i] << sh) : (m[i] >> (-sh));
      sumsq = sumsq + m[i] * m[i];
    end
    s = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (s >> 1)) / s;
      u[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
    lsh = sh;
  endtask

  // exact length test against the threshold, scaled back to Q4.60
  function automatic bit too_short(input logic [63:0] sumsq, input int lsh,
                                   input logic [THR_W-1:0] t);
    logic [63:0] t2;
    int e;
    t2 = 64'(t) * 64'(t);
    e = 60 + 2 * lsh;
    if (t == 0) return 1'b0;
    if (sumsq == 0) return 1'b1;
    if (e >= 0) begin
      if (e >= 63 || t2 > ({64{1'b1}} >> e)) return 1'b1;
      return sumsq < (t2 << e);
    end
    e = -e;
    if (e >= 64 || sumsq > ({64{1'b1}} >> e)) return 1'b0;
    return (sumsq << e) < t2;
  endfunction

  function automatic logic signed [31:0] q60_round(input logic signed [63:0] v);
    logic [63:0] q;
    q = (abs64(v) + (64'd1 << 29)) >> 30;
    if (v[63]) q60_round = (q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    else       q60_round = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  // computes the three rows of one request and updates the saved right axis
  task automatic predict_rows(input view_req_t r);
    logic signed [63:0] eye [3], d [3], up [3], f [3], c [3], rt [3], nu [3];
    logic [63:0] ss;
    int sh;
    bit fb;
    row_res_t o;
    eye[0] = r.ex; eye[1] = r.ey; eye[2] = r.ez;
    d[0] = eye[0] - 64'(r.tx); d[1] = eye[1] - 64'(r.ty); d[2] = eye[2] - 64'(r.tz);
    up[0] = r.ux; up[1] = r.uy; up[2] = r.uz;
    to_unit(d, f, ss, sh);
    c[0] = up[1] * f[2] - up[2] * f[1];
    c[1] = up[2] * f[0] - up[0] * f[2];
    c[2] = up[0] * f[1] - up[1] * f[0];
    to_unit(c, rt, ss, sh);
    fb = too_short(ss, sh, pr_thresh);
    for (int i = 0; i < 3; i++) begin
      if (fb) rt[i] = pr_saved[i];
      else    pr_saved[i] = rt[i][31:0];
    end
    nu[0] = q60_round(f[1] * rt[2] - f[2] * rt[1]);
    nu[1] = q60_round(f[2] * rt[0] - f[0] * rt[2]);
    nu[2] = q60_round(f[0] * rt[1] - f[1] * rt[0]);
    for (int i = 0; i < 3; i++) begin
      o.row  = 2'(i);
      o.rgt  = rt[i][31:0];
      o.upw  = nu[i][31:0];
      o.fwd  = f[i][31:0];
      o.pos  = eye[i][31:0];
      o.last = (2'(i) == ROW_LAST);
      o.fb   = fb;
      row_q.push_back(o);
    end
  endtask

  // ---------------------------------------------------------------------
  // receiver: random idling plus a long hold-off when asked
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= idle_out ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  // compare each accepted row with the oldest expectation
  always @(posedge clk) begin
    row_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (row_q.size() == 0) begin
        $error("unexpected row %0d", out_row_index);
        errors++;
      end else begin
        e = row_q.pop_front();
        if (out_row_index !== e.row) begin
          $error("row_index exp %0d got %0d", e.row, out_row_index); errors++;
        end
        if (out_right_part !== e.rgt) begin
          $error("right_part exp %0d got %0d", e.rgt, out_right_part); errors++;
        end
        if (out_upward_part !== e.upw) begin
          $error("upward_part exp %0d got %0d", e.upw, out_upward_part); errors++;
        end
        if (out_forward_part !== e.fwd) begin
          $error("forward_part exp %0d got %0d", e.fwd, out_forward_part); errors++;
        end
        if (out_position_part !== e.pos) begin
          $error("position_part exp %0d got %0d", e.pos, out_position_part); errors++;
        end
        if (out_last_row !== e.last) begin
          $error("last_row exp %0d got %0d", e.last, out_last_row); errors++;
        end
        if (out_fallback_used !== e.fb) begin
          $error("fallback_used exp %0d got %0d", e.fb, out_fallback_used); errors++;
        end
      end
    end
  end

  // watchdog on a free-running cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------
  // offer one request and hold it until the block takes it; valid drops
  // after the accept and stays low while the sender idles at random
  task automatic send_req(input view_req_t r);
    while (idle_in && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    predict_rows(r);
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected row, then a latency margin, before a register write
  task automatic drain_all();
    while (row_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_thresh(input logic [THR_W-1:0] t);
    drain_all();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    pr_thresh = t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(5))
      0:       rnd_word = 32'sh7FFF_FFFF;
      1:       rnd_word = 32'sh8000_0000;
      2:       rnd_word = $signed(32'($urandom_range(2048))) - 1024;
      default: rnd_word = $signed($urandom());
    endcase
  endfunction

  // mostly sane camera setups; some random garbage, eye-on-target and up-along-forward cases
  function automatic view_req_t rnd_req();
    view_req_t r;
    int kind;
    kind = $urandom_range(9);
    r.ex = rnd_word(); r.ey = rnd_word(); r.ez = rnd_word();
    r.tx = rnd_word(); r.ty = rnd_word(); r.tz = rnd_word();
    r.ux = rnd_word(); r.uy = rnd_word(); r.uz = rnd_word();
    if (kind < 6) begin
      // scene-scale coordinates, unit-ish up hint
      r.ex = $signed($urandom()) >>> $urandom_range(12);
      r.ey = $signed($urandom()) >>> $urandom_range(12);
      r.ez = $signed($urandom()) >>> $urandom_range(12);
      r.tx = $signed($urandom()) >>> $urandom_range(12);
      r.ty = $signed($urandom()) >>> $urandom_range(12);
      r.tz = $signed($urandom()) >>> $urandom_range(12);
      r.ux = $signed($urandom()) >>> (2 + $urandom_range(8));
      r.uy = $signed($urandom()) >>> (2 + $urandom_range(8));
      r.uz = $signed($urandom()) >>> (2 + $urandom_range(8));
    end else if (kind == 6) begin
      r.tx = r.ex; r.ty = r.ey; r.tz = r.ez;
    end else if (kind == 7) begin
      // up hint along forward: degenerate right axis
      r.ux = r.ex - r.tx; r.uy = r.ey - r.ty; r.uz = r.ez - r.tz;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  dir_row_t dir_tbl [$];

  task automatic add_dir(input view_req_t r, input logic has0, input row_res_t r0);
    dir_row_t d;
    d.req = r; d.has_row0 = has0; d.row0 = r0;
    dir_tbl.push_back(d);
  endtask

  initial begin
    view_req_t r;
    row_res_t  z, h;
    int        n_rows;
    localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE16 = 32'sh0001_0000;

    errors = 0; cycles = 0; hold_off = 0;
    idle_in = 1'b0; idle_out = 1'b0;
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_valid = 1'b0; in_req = '0;
    pr_thresh = THR_RESET;
    pr_saved[0] = ONE_Q30; pr_saved[1] = 0; pr_saved[2] = 0;
    z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // eye on target right after reset: zero forward, reset right axis reused
    r = '0;
    h = '{row: 2'd0, rgt: ONE_Q30, upw: 0, fwd: 0, pos: 0, last: 1'b0, fb: 1'b1};
    add_dir(r, 1'b1, h);
    // looking down -z with up +y: right is +x, up is +y
    r = '{ex: 0, ey: 0, ez: ONE16, tx: 0, ty: 0, tz: 0, ux: 0, uy: ONE_Q30, uz: 0};
    h = '{row: 2'd0, rgt: ONE_Q30, upw: 0, fwd: 0, pos: 0, last: 1'b0, fb: 1'b0};
    add_dir(r, 1'b1, h);
    // field extremes
    r = '{ex: MAXP, ey: MINN, ez: MAXP, tx: MINN, ty: MAXP, tz: MINN,
          ux: MAXP, uy: MINN, uz: MAXP};
    add_dir(r, 1'b0, z);
    r = '{ex: MINN, ey: MINN, ez: MINN, tx: MAXP, ty: MAXP, tz: MAXP,
          ux: MINN, uy: MINN, uz: MINN};
    add_dir(r, 1'b0, z);
    r = '{ex: MINN, ey: MAXP, ez: 1, tx: MAXP, ty: MINN, tz: -1,
          ux: MINN, uy: MAXP, uz: -1};
    add_dir(r, 1'b0, z);
    r = '{ex: -1, ey: -1, ez: -1, tx: -1, ty: -1, tz: -1, ux: -1, uy: -1, uz: -1};
    add_dir(r, 1'b0, z);
    // smallest possible forward vector
    r = '{ex: 1, ey: 0, ez: 0, tx: 0, ty: 0, tz: 0, ux: 0, uy: 1, uz: 0};
    add_dir(r, 1'b0, z);
    // up hint parallel to forward: degenerate right, saved axis reused
    r = '{ex: 0, ey: ONE16, ez: 0, tx: 0, ty: 0, tz: 0, ux: 0, uy: ONE_Q30, uz: 0};
    add_dir(r, 1'b0, z);
    // zero up hint
    r = '{ex: 5, ey: -7, ez: 3, tx: 0, ty: 0, tz: 0, ux: 0, uy: 0, uz: 0};
    add_dir(r, 1'b0, z);
    // oblique camera
    r = '{ex: 32'sh0003_0000, ey: 32'sh0002_0000, ez: -32'sh0004_0000, tx: 1, ty: -3,
          tz: 9, ux: 32'sh1000_0000, uy: ONE_Q30, uz: -32'sh0800_0000};
    add_dir(r, 1'b0, z);
    // tiny up hint: cross product barely above or below the threshold
    r = '{ex: 0, ey: 0, ez: ONE16, tx: 0, ty: 0, tz: 0, ux: 0, uy: 1, uz: 0};
    add_dir(r, 1'b0, z);
    r = '{ex: 0, ey: 0, ez: ONE16, tx: 0, ty: 0, tz: 0, ux: 0, uy: 1500, uz: 0};
    add_dir(r, 1'b0, z);

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].req);
      // earlier rows are all out once the block takes a request
      n_rows = row_q.size() - 3;
      if (dir_tbl[i].has_row0 && row_q[n_rows] !== dir_tbl[i].row0) begin
        $error("table row %0d: first row exp %p got %p", i, dir_tbl[i].row0, row_q[n_rows]);
        errors++;
      end
    end

    // zero threshold: a zero right axis is taken as is and saved
    write_thresh('0);
    r = '0;
    send_req(r);
    r = '{ex: 0, ey: ONE16, ez: 0, tx: 0, ty: 0, tz: 0, ux: 0, uy: 2, uz: 0};
    send_req(r);
    // largest threshold: nearly every request falls back
    write_thresh('1);
    for (int i = 0; i < 4; i++) send_req(rnd_req());
    write_thresh(31'(ONE_Q30));
    for (int i = 0; i < 4; i++) send_req(rnd_req());

    // random part with settings changes between phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_thresh(THR_RESET);
        1: write_thresh(31'($urandom_range(1 << 20)));
        2: write_thresh(31'($urandom()));
        3: write_thresh(31'd1);
        default: write_thresh(THR_RESET);
      endcase
      idle_in  = (ph != 1);
      idle_out = (ph != 1);
      for (int i = 0; i < 48; i++) begin
        // long receiver hold-off while the sender keeps offering requests
        if (ph == 2 && i == 10) hold_off = 300;
        send_req(rnd_req());
      end
      // sender pauses until all rows are back
      if (ph == 3) while (row_q.size() != 0) @(posedge clk);
    end

    while (row_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else             $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
